// File: sv/bfsf_pkg.sv
// Package for the bitmap free slot finder: field widths, command and state codes,
// controller/datapath command and status structs, and the 32-bit popcount function.
// No dependencies.
package bfsf_pkg;

    localparam int WORD_BITS = 32;
    localparam int CMD_W     = 2;
    localparam int WIDX_W    = 7;
    localparam int POS_W     = 13;
    localparam int SLOT_W    = 12;
    localparam int TALLY_W   = 13;
    localparam int CFG_W     = 13;

    localparam logic [CFG_W-1:0] BITMAP_BITS_RESET = 13'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE       = 2'd0,
        CMD_FIND        = 2'd1,
        CMD_COUNT_USED  = 2'd2,
        CMD_COUNT_PAGES = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_WRAP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic walk;
        logic wrap;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic walk_busy;
        logic found;
        logic needs_wrap;
        logic out_full;
    } dp_status_t;

    function automatic logic [5:0] pop32(input logic [31:0] v);
        logic [31:0] c;
        c = (v & 32'h55555555) + ((v >> 1) & 32'h55555555);
        c = (c & 32'h33333333) + ((c >> 2) & 32'h33333333);
        c = (c & 32'h0F0F0F0F) + ((c >> 4) & 32'h0F0F0F0F);
        c = (c & 32'h00FF00FF) + ((c >> 8) & 32'h00FF00FF);
        c = (c & 32'h0000FFFF) + ((c >> 16) & 32'h0000FFFF);
        return c[5:0];
    endfunction

endpackage

// File: sv/bfsf_in_if.sv
// Input channel of the bitmap free slot finder: valid/ready plus one command item.
// Depends on bfsf_pkg.
interface bfsf_in_if;
    import bfsf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [WIDX_W-1:0] word_index;
    logic [31:0]       word_data;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  length_limit;

    modport source (
        output valid, command, word_index, word_data, start_pos, length_limit,
        input  ready
    );

    modport sink (
        input  valid, command, word_index, word_data, start_pos, length_limit,
        output ready
    );
endinterface

// File: sv/bfsf_out_if.sv
// Result channel of the bitmap free slot finder: valid/ready plus one result item.
// Depends on bfsf_pkg.
interface bfsf_out_if;
    import bfsf_pkg::*;

    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  slot_index;
    logic               found;
    logic [TALLY_W-1:0] tally;

    modport source (
        output valid, slot_index, found, tally,
        input  ready
    );

    modport sink (
        input  valid, slot_index, found, tally,
        output ready
    );
endinterface

// File: sv/bfsf_datapath.sv
// Datapath of the bitmap free slot finder: bitmap memory, word walker, search and
// count evaluation, configuration register and result register.
// Depends on bfsf_pkg; driven by bfsf_controller commands.
module bfsf_datapath #(
    parameter int MAP_WORDS = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bfsf_pkg::ctrl_cmd_t          cmd,
    output bfsf_pkg::dp_status_t         sts,
    input  logic                         cfg_wr_en,
    input  logic [bfsf_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic [bfsf_pkg::CMD_W-1:0]   command,
    input  logic [bfsf_pkg::WIDX_W-1:0]  word_index,
    input  logic [31:0]                  word_data,
    input  logic [bfsf_pkg::POS_W-1:0]   start_pos,
    input  logic [bfsf_pkg::POS_W-1:0]   length_limit,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [bfsf_pkg::SLOT_W-1:0]  slot_index,
    output logic                         found,
    output logic [bfsf_pkg::TALLY_W-1:0] tally
);
    import bfsf_pkg::*;

    localparam int TOTAL_BITS = MAP_WORDS * WORD_BITS;
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW = $clog2(MAP_WORDS + 1);

    logic [31:0] mem [0:MAP_WORDS-1];

    logic [CFG_W-1:0]   bitmap_bits_reg;
    cmd_t               op_reg;
    logic [POS_W-1:0]   lo_reg, lo_next;
    logic [POS_W-1:0]   hi_reg, hi_next;
    logic [CW-1:0]      addr_reg, addr_next;
    logic [CW-1:0]      last_reg, last_next;
    logic               issue_reg, issue_next;
    logic               phase_reg, phase_next;
    logic [31:0]        rd_data_reg;
    logic [CW-1:0]      rd_word_reg;
    logic               rd_vld_reg;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [TALLY_W-1:0] acc_reg, acc_next;
    logic               out_valid_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_found_reg;
    logic [TALLY_W-1:0] out_tally_reg;

    cmd_t             cmd_in;
    logic [POS_W-1:0] lim_bits_sat, lim_bits_m1;
    logic [POS_W-1:0] lim_words_sat, lim_words_m1;
    logic [CW-1:0]    used_last;
    logic             start_ok;
    logic [POS_W-1:0] wrap_m1;
    logic [POS_W-1:0] hi_m1;
    logic             wr_hit;
    logic [31:0]      mask_lo, mask_hi, free_bits;
    logic [4:0]       bit_sel;
    logic [CW+4:0]    slot_full;

    assign cmd_in        = cmd_t'(command);
    assign lim_bits_sat  = (32'(length_limit) > TOTAL_BITS) ? POS_W'(TOTAL_BITS) : length_limit;
    assign lim_bits_m1   = lim_bits_sat - POS_W'(1);
    assign lim_words_sat = (32'(length_limit) > MAP_WORDS) ? POS_W'(MAP_WORDS) : length_limit;
    assign lim_words_m1  = lim_words_sat - POS_W'(1);
    assign used_last     = (32'(bitmap_bits_reg[12:5]) > MAP_WORDS - 1)
                         ? CW'(MAP_WORDS - 1) : CW'(bitmap_bits_reg[12:5]);
    assign start_ok      = start_pos <= lim_bits_sat;
    assign wrap_m1       = lo_reg - POS_W'(1);
    assign hi_m1         = hi_reg - POS_W'(1);
    assign wr_hit        = 32'(word_index) < MAP_WORDS;

    always_comb
    begin
        mask_lo = (32'(rd_word_reg) == 32'(lo_reg[12:5])) ? (32'hFFFFFFFF << lo_reg[4:0])
                                                           : 32'hFFFFFFFF;
        mask_hi = (32'(rd_word_reg) == 32'(hi_m1[12:5])) ? ~(32'hFFFFFFFE << hi_m1[4:0])
                                                          : 32'hFFFFFFFF;
        free_bits = ~rd_data_reg & mask_lo & mask_hi;
        bit_sel = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                bit_sel = 5'(i);
            end
        end
        slot_full = {rd_word_reg, bit_sel};
    end

    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        addr_next  = addr_reg;
        last_next  = last_reg;
        issue_next = issue_reg;
        phase_next = phase_reg;
        found_next = found_reg;
        slot_next  = slot_reg;
        acc_next   = acc_reg;

        if (cmd.clear_step)
        begin
            addr_next = addr_reg + CW'(1);
        end
        else if (cmd.load)
        begin
            found_next = 1'b0;
            slot_next  = '0;
            acc_next   = '0;
            addr_next  = '0;
            last_next  = '0;
            lo_next    = start_pos;
            hi_next    = lim_bits_sat;
            case (cmd_in)
                CMD_WRITE:
                begin
                    issue_next = 1'b0;
                    phase_next = 1'b1;
                end
                CMD_FIND:
                begin
                    addr_next  = CW'(start_pos[12:5]);
                    last_next  = CW'(lim_bits_m1[12:5]);
                    issue_next = start_ok && (start_pos < lim_bits_sat);
                    phase_next = !start_ok;
                end
                CMD_COUNT_USED:
                begin
                    last_next  = used_last;
                    issue_next = 1'b1;
                    phase_next = 1'b1;
                end
                CMD_COUNT_PAGES:
                begin
                    last_next  = CW'(lim_words_m1);
                    issue_next = length_limit != '0;
                    phase_next = 1'b1;
                end
                default:
                begin
                    issue_next = 1'b0;
                    phase_next = 1'b1;
                end
            endcase
        end
        else if (cmd.wrap)
        begin
            lo_next    = '0;
            hi_next    = lo_reg;
            addr_next  = '0;
            last_next  = CW'(wrap_m1[12:5]);
            issue_next = lo_reg != '0;
            phase_next = 1'b1;
        end
        else if (cmd.finish)
        begin
            issue_next = 1'b0;
        end
        else if (cmd.walk && issue_reg)
        begin
            if (addr_reg == last_reg)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + CW'(1);
            end
        end

        if (rd_vld_reg && !cmd.load)
        begin
            case (op_reg)
                CMD_FIND:
                begin
                    if (!found_reg && (free_bits != '0))
                    begin
                        found_next = 1'b1;
                        slot_next  = SLOT_W'(slot_full);
                    end
                end
                CMD_COUNT_USED:
                begin
                    acc_next = acc_reg + TALLY_W'(pop32(rd_data_reg));
                end
                CMD_COUNT_PAGES:
                begin
                    acc_next = acc_reg + TALLY_W'(rd_data_reg != '0);
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            mem[addr_reg[AW-1:0]] <= '0;
        end
        else if (cmd.load && (cmd_in == CMD_WRITE) && wr_hit)
        begin
            mem[AW'(word_index)] <= word_data;
        end
        rd_data_reg <= mem[addr_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_bits_reg <= BITMAP_BITS_RESET;
            addr_reg        <= '0;
            issue_reg       <= 1'b0;
            phase_reg       <= 1'b1;
            rd_vld_reg      <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bitmap_bits_reg <= cfg_wr_data;
            end
            addr_reg   <= addr_next;
            issue_reg  <= issue_next;
            phase_reg  <= phase_next;
            rd_vld_reg <= cmd.walk && issue_reg;
            found_reg  <= found_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= cmd_in;
        end
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        last_reg    <= last_next;
        rd_word_reg <= addr_reg;
        slot_reg    <= slot_next;
        acc_reg     <= acc_next;
        if (cmd.finish)
        begin
            out_slot_reg  <= slot_reg;
            out_found_reg <= found_reg;
            out_tally_reg <= acc_reg;
        end
    end

    assign sts.clear_done = 32'(addr_reg) == MAP_WORDS - 1;
    assign sts.walk_busy  = issue_reg || rd_vld_reg;
    assign sts.found      = found_reg;
    assign sts.needs_wrap = (op_reg == CMD_FIND) && !phase_reg && !found_reg;
    assign sts.out_full   = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign slot_index = out_slot_reg;
    assign found      = out_found_reg;
    assign tally      = out_tally_reg;

    a_found_only_find: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (op_reg == CMD_FIND))
        else $error("found flag set for a non-search command");

    a_read_follows_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> $past(cmd.walk))
        else $error("read data tagged valid without a walk step");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("result register not valid after finish");

    a_load_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !issue_reg && !cmd.clear_step)
        else $error("item loaded while a walk or clear is running");
endmodule

// File: sv/bfsf_controller.sv
// Controller of the bitmap free slot finder: clear pass, item intake, word walk,
// wrap to the second search range and result hand-off.
// Depends on bfsf_pkg; commands bfsf_datapath.
module bfsf_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bfsf_pkg::dp_status_t sts,
    output bfsf_pkg::ctrl_cmd_t  cmd
);
    import bfsf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.found || !sts.walk_busy)
                begin
                    state_next = sts.needs_wrap ? S_WRAP : S_FINISH;
                end
            end
            S_WRAP:
            begin
                cmd.wrap   = 1'b1;
                state_next = S_WALK;
            end
            S_FINISH:
            begin
                if (!sts.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// File: sv/bitmap_free_slot_finder_unit.sv
// Bitmap free slot finder, top level. Commands walk the bitmap word by word through the single memory
// read port; a write walks no word, and a wrapped find walks at most MAP_WORDS + 1 words.
// One item at a time: the next item is taken the cycle after the result register is loaded.
// Reset: the bitmap is zeroed word by word, no item taken; bitmap_bits resets to 4096.
// Depends on bfsf_pkg, bfsf_in_if, bfsf_out_if, bfsf_controller, bfsf_datapath.
module bitmap_free_slot_finder_unit #(
    parameter int MAP_WORDS = 128
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bfsf_in_if.sink                    request,
    bfsf_out_if.source                 result,
    input  logic                       cfg_wr_en,
    input  logic [bfsf_pkg::CFG_W-1:0] cfg_wr_data
);
    import bfsf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    bfsf_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfsf_datapath #(
        .MAP_WORDS (MAP_WORDS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .command      (request.command),
        .word_index   (request.word_index),
        .word_data    (request.word_data),
        .start_pos    (request.start_pos),
        .length_limit (request.length_limit),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .slot_index   (result.slot_index),
        .found        (result.found),
        .tally        (result.tally)
    );
endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for bitmap_free_slot_finder_unit: directed table, then random command mixes
// under several bitmap_bits settings, checked against an in-bench bitmap predictor or typed table rows.
// Depends on bfsf_pkg, bfsf_in_if, bfsf_out_if and the block itself.
module testbench;
    import bfsf_pkg::*;

    localparam int MAP_WORDS    = 128;
    localparam int TOTAL_BITS   = MAP_WORDS * WORD_BITS;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int PHASE_ITEMS  = 235;
    localparam int NUM_PHASES   = 7;
    localparam int DIR_ROWS     = 21;

    typedef struct packed {
        cmd_t              cmd;
        logic [WIDX_W-1:0] widx;
        logic [31:0]       wdata;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  lim;
    } bitmap_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               found;
        logic [TALLY_W-1:0] tally;
    } slot_result_t;

    typedef struct packed {
        bitmap_req_t  req;
        logic         typed;
        slot_result_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    bfsf_in_if  request_ch ();
    bfsf_out_if result_ch ();

    bitmap_free_slot_finder_unit #(
        .MAP_WORDS (MAP_WORDS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    logic [31:0]      bitmap_model [MAP_WORDS];
    logic [CFG_W-1:0] model_bitmap_bits;
    slot_result_t     pending_results [$];
    stim_row_t        stim_rows [DIR_ROWS];

    int  mismatches   = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  find_hits    = 0;
    int  find_misses  = 0;
    int  cycle_count  = 0;
    bit  no_idle      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("bitmap_free_slot_finder_unit regression: fail");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic slot_result_t predict_slot_result(input bitmap_req_t it);
        slot_result_t r;
        int lim;
        int pos;
        int n;
        int sum;
        r   = '0;
        sum = 0;
        case (it.cmd)
            CMD_WRITE:
            begin
                if (int'(it.widx) < MAP_WORDS)
                    bitmap_model[it.widx] = it.wdata;
            end
            CMD_FIND:
            begin
                lim = (int'(it.lim) > TOTAL_BITS) ? TOTAL_BITS : int'(it.lim);
                pos = int'(it.pos);
                if (pos <= lim)
                begin
                    for (int i = pos; i < lim && !r.found; i++)
                        if (!bitmap_model[i / WORD_BITS][i % WORD_BITS])
                        begin
                            r.found = 1'b1;
                            r.slot  = i[SLOT_W-1:0];
                        end
                    for (int i = 0; i < pos && !r.found; i++)
                        if (!bitmap_model[i / WORD_BITS][i % WORD_BITS])
                        begin
                            r.found = 1'b1;
                            r.slot  = i[SLOT_W-1:0];
                        end
                end
                if (r.found)
                    find_hits++;
                else
                    find_misses++;
            end
            CMD_COUNT_USED:
            begin
                n = int'(model_bitmap_bits) / WORD_BITS + 1;
                if (n > MAP_WORDS)
                    n = MAP_WORDS;
                for (int i = 0; i < n; i++)
                    sum += $countones(bitmap_model[i]);
                r.tally = sum[TALLY_W-1:0];
            end
            default:
            begin
                n = (int'(it.lim) > MAP_WORDS) ? MAP_WORDS : int'(it.lim);
                for (int i = 0; i < n; i++)
                    if (bitmap_model[i] != 32'h0)
                        sum++;
                r.tally = sum[TALLY_W-1:0];
            end
        endcase
        return r;
    endfunction

    function automatic bitmap_req_t random_request();
        bitmap_req_t it;
        int r;
        it.widx  = WIDX_W'($urandom);
        it.wdata = $urandom;
        it.pos   = POS_W'($urandom);
        it.lim   = POS_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            it.cmd = CMD_WRITE;
            r = $urandom_range(0, 99);
            if (r < 45)
                it.wdata = 32'hFFFF_FFFF;
            else if (r < 60)
                it.wdata = 32'h0;
            else if (r < 80)
                it.wdata = ~(32'h1 << $urandom_range(0, 31));
        end
        else if (r < 75)
        begin
            it.cmd = CMD_FIND;
            if ($urandom_range(0, 9) != 0)
                it.pos = POS_W'($urandom_range(0, TOTAL_BITS));
            r = $urandom_range(0, 99);
            if (r < 70)
                it.lim = POS_W'(TOTAL_BITS);
            else if (r < 85)
                it.lim = POS_W'($urandom_range(0, TOTAL_BITS));
        end
        else if (r < 88)
        begin
            it.cmd = CMD_COUNT_USED;
        end
        else
        begin
            it.cmd = CMD_COUNT_PAGES;
            r = $urandom_range(0, 99);
            if (r < 60)
                it.lim = POS_W'($urandom_range(0, MAP_WORDS));
            else if (r < 80)
                it.lim = POS_W'(MAP_WORDS);
        end
        return it;
    endfunction

    function automatic stim_row_t make_row(input cmd_t cmd, input int widx, input logic [31:0] wdata,
                                           input int pos, input int lim, input logic typed,
                                           input int slot, input logic found, input int tally);
        stim_row_t row;
        row.req.cmd   = cmd;
        row.req.widx  = WIDX_W'(widx);
        row.req.wdata = wdata;
        row.req.pos   = POS_W'(pos);
        row.req.lim   = POS_W'(lim);
        row.typed     = typed;
        row.res.slot  = SLOT_W'(slot);
        row.res.found = found;
        row.res.tally = TALLY_W'(tally);
        return row;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got,
                 want);
        mismatches++;
    endtask

    task automatic send_request(input bitmap_req_t it, input logic typed,
                                input slot_result_t typed_res);
        int gap;
        slot_result_t want;
        gap = idle_gap();
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid        <= 1'b1;
        request_ch.command      <= it.cmd;
        request_ch.word_index   <= it.widx;
        request_ch.word_data    <= it.wdata;
        request_ch.start_pos    <= it.pos;
        request_ch.length_limit <= it.lim;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        want = predict_slot_result(it);
        if (typed)
            want = typed_res;
        pending_results.push_back(want);
        items_sent++;
    endtask

    task automatic set_bitmap_bits(input logic [CFG_W-1:0] bits);
        request_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_wr_en         <= 1'b1;
        cfg_wr_data       <= bits;
        model_bitmap_bits  = bits;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: check every accepted item, stall at random
    initial
    begin
        int stall_left;
        slot_result_t want;
        stall_left      = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result, tally", result_ch.tally, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_ch.slot_index !== want.slot)
                        report_mismatch("slot_index", result_ch.slot_index, want.slot);
                    if (result_ch.found !== want.found)
                        report_mismatch("found", result_ch.found, want.found);
                    if (result_ch.tally !== want.tally)
                        report_mismatch("tally", result_ch.tally, want.tally);
                end
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_gap();
            end
        end
    end

    initial
    begin
        logic [CFG_W-1:0] bits_settings [NUM_PHASES];
        bitmap_req_t it;
        rst_n                   <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_wr_data             <= '0;
        request_ch.valid        <= 1'b0;
        request_ch.command      <= CMD_WRITE;
        request_ch.word_index   <= '0;
        request_ch.word_data    <= '0;
        request_ch.start_pos    <= '0;
        request_ch.length_limit <= '0;
        for (int w = 0; w < MAP_WORDS; w++)
            bitmap_model[w] = 32'h0;
        model_bitmap_bits = BITMAP_BITS_RESET;

        stim_rows[0]  = make_row(CMD_FIND,        0, 32'h0,         0,    4096, 1, 0, 1, 0);
        stim_rows[1]  = make_row(CMD_COUNT_USED,  0, 32'h0,         0,    0,    1, 0, 0, 0);
        stim_rows[2]  = make_row(CMD_COUNT_PAGES, 0, 32'h0,         0,    8191, 1, 0, 0, 0);
        stim_rows[3]  = make_row(CMD_WRITE,       0, 32'hFFFF_FFFF, 8191, 8191, 1, 0, 0, 0);
        stim_rows[4]  = make_row(CMD_WRITE,     127, 32'hFFFF_FFFF, 0,    0,    1, 0, 0, 0);
        stim_rows[5]  = make_row(CMD_WRITE,       1, 32'hFFFF_FFFF, 0,    0,    1, 0, 0, 0);
        stim_rows[6]  = make_row(CMD_WRITE,       2, 32'h7FFF_FFFF, 0,    0,    1, 0, 0, 0);
        stim_rows[7]  = make_row(CMD_FIND,        0, 32'h0,         0,    4096, 0, 0, 0, 0);
        stim_rows[8]  = make_row(CMD_FIND,        0, 32'h0,         0,    32,   1, 0, 0, 0);
        stim_rows[9]  = make_row(CMD_FIND,        0, 32'h0,         100,  50,   1, 0, 0, 0);
        stim_rows[10] = make_row(CMD_FIND,        0, 32'h0,         8191, 8191, 1, 0, 0, 0);
        stim_rows[11] = make_row(CMD_FIND,        0, 32'h0,         4096, 8191, 0, 0, 0, 0);
        stim_rows[12] = make_row(CMD_FIND,        0, 32'h0,         4090, 4096, 0, 0, 0, 0);
        stim_rows[13] = make_row(CMD_FIND,        0, 32'h0,         0,    0,    1, 0, 0, 0);
        stim_rows[14] = make_row(CMD_COUNT_USED,  0, 32'h0,         0,    0,    0, 0, 0, 0);
        stim_rows[15] = make_row(CMD_COUNT_PAGES, 0, 32'h0,         0,    0,    1, 0, 0, 0);
        stim_rows[16] = make_row(CMD_COUNT_PAGES, 0, 32'h0,         0,    2,    0, 0, 0, 0);
        stim_rows[17] = make_row(CMD_COUNT_PAGES, 0, 32'h0,         0,    8191, 0, 0, 0, 0);
        stim_rows[18] = make_row(CMD_WRITE,      64, 32'h8000_0001, 0,    0,    1, 0, 0, 0);
        stim_rows[19] = make_row(CMD_WRITE,       0, 32'h0,         0,    0,    1, 0, 0, 0);
        stim_rows[20] = make_row(CMD_FIND,        0, 32'h0,         1,    4096, 0, 0, 0, 0);

        bits_settings = '{13'd4096, 13'd0, 13'd8191, 13'd31, 13'd4095, 13'd32, 13'd0};
        bits_settings[NUM_PHASES-1] = CFG_W'($urandom_range(0, 8191));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++)
            send_request(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].res);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_bitmap_bits(bits_settings[p]);
            no_idle = (p == 4);
            // fill the whole map so that searches walk the full range and wrap
            if (p == 2)
            begin
                for (int w = 0; w < MAP_WORDS; w++)
                begin
                    it       = random_request();
                    it.cmd   = CMD_WRITE;
                    it.widx  = WIDX_W'(w);
                    it.wdata = 32'hFFFF_FFFF;
                    send_request(it, 1'b0, '0);
                end
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request(), 1'b0, '0);
        end
        no_idle = 0;
        request_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("%0d items sent, %0d results checked, %0d bitmap_bits settings",
                 items_sent, results_seen, NUM_PHASES);
        $display("find: %0d hits, %0d misses; %0d mismatches", find_hits, find_misses,
                 mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("bitmap_free_slot_finder_unit regression: pass");
        else
            $display("bitmap_free_slot_finder_unit regression: fail");
        $finish;
    end

endmodule

// File: bitmap_free_slot_finder_unit.f
sv/bfsf_pkg.sv
sv/bfsf_in_if.sv
sv/bfsf_out_if.sv
sv/bfsf_datapath.sv
sv/bfsf_controller.sv
sv/bitmap_free_slot_finder_unit.sv
verif/testbench.sv
